>>> hw/rtl/command_argument_tokenizer_core_defines.svh
// Assertion macros shared by the tokenizer RTL.
// Define ASSERT_OFF to compile every check away.
`ifndef COMMAND_ARGUMENT_TOKENIZER_CORE_DEFINES_SVH
`define COMMAND_ARGUMENT_TOKENIZER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// Property holds on every clock edge outside reset.
`define CAT_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("check failed");
// Antecedent implies consequent in the same cycle.
`define CAT_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");
// Antecedent implies consequent in the next cycle.
`define CAT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");
`else
`define CAT_ASSERT_ALWAYS(lbl, expr)
`define CAT_ASSERT_SAME(lbl, ante, cons)
`define CAT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> hw/rtl/cat_pkg.sv
// Package of the command argument tokenizer: item types, codes, constants.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package cat_pkg;

  localparam int LINE_BYTES_DEFAULT = 256;
  localparam int MAX_ARGS_DEFAULT   = 8;
  localparam int QUEUE_DEPTH        = 4;

  // Result kinds
  localparam logic [1:0] KIND_NAME    = 2'd0;
  localparam logic [1:0] KIND_ARG     = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  // Summary status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_NAME  = 2'd1;
  localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

  // Characters
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_NAME,
    PH_AFTER,
    PH_BRACKET,
    PH_BLANKARGS,
    PH_END,
    PH_NONAME
  } phase_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] token_kind;
    logic [7:0] token_offset;
    logic [8:0] token_size;
    logic [3:0] arg_total;
    logic [1:0] parse_status;
    logic       end_of_run;
  } out_item_t;

  // One queue entry: the results caused by one byte (token first, then summary).
  typedef struct packed {
    logic       tok_valid;
    logic [1:0] tok_kind;
    logic [7:0] tok_offset;
    logic [8:0] tok_length;
    logic [3:0] tok_total;
    logic       sum_valid;
    logic [1:0] sum_status;
    logic [3:0] sum_total;
  } step_rec_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR);
  endfunction

  function automatic logic is_sep(input logic [7:0] c);
    return (c == CH_COMMA) || (c == CH_SEMI);
  endfunction

  function automatic logic is_term(input logic [7:0] c);
    return (c == CH_LF) || (c == CH_NUL);
  endfunction

endpackage

>>> hw/rtl/cat_stream_if.sv
// Valid/ready stream channel carrying one payload item per transaction.
// Payload type is set per instance; no package dependency.
`timescale 1ns / 1ps

interface cat_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/cat_front.sv
// Front end: accepts bytes, runs the line scanner, emits one step record per
// byte that causes results. Depends on cat_pkg and cat_stream_if.
`timescale 1ns / 1ps
`include "command_argument_tokenizer_core_defines.svh"

module cat_front #(
  parameter int LINE_BYTES = cat_pkg::LINE_BYTES_DEFAULT,
  parameter int MAX_ARGS   = cat_pkg::MAX_ARGS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  cat_stream_if.sink         byte_in,
  input  logic               room,
  output logic               push,
  output cat_pkg::step_rec_t rec
);
  import cat_pkg::*;

  localparam int POS_RAW = $clog2(LINE_BYTES + 1);
  localparam int POS_W   = (POS_RAW < 9) ? 9 : POS_RAW;
  localparam int ARG_RAW = $clog2(MAX_ARGS + 1);
  localparam int ARG_W   = (ARG_RAW < 4) ? 4 : ARG_RAW;

  phase_t             phase, phase_next;
  logic [POS_W-1:0]   byte_position, byte_position_next;
  logic [POS_W-1:0]   token_begin, token_begin_next;
  logic               inside_token, inside_token_next;
  logic [ARG_W-1:0]   args_found, args_found_next;
  logic               overflow_seen, overflow_seen_next;

  // Step decisions shared by the output block
  logic               emit_take;
  logic               emit_take_arg;
  logic [ARG_W-1:0]   take_total;
  logic               emit_close;
  logic               close_arg;
  logic [POS_W-1:0]   close_begin;
  logic [POS_W-1:0]   close_pos;
  logic [ARG_W-1:0]   final_total;
  logic [1:0]         final_status;

  logic               accept;
  logic [7:0]         c;
  logic               last;

  assign byte_in.ready = room;
  assign accept        = byte_in.valid && room;
  assign c             = byte_in.data.byte_value;
  assign last          = byte_in.data.last_byte;

  // Next state of the scanner for the byte on the input
  always_comb begin
    phase_t           ph;
    logic             ins;
    logic [POS_W-1:0] beg;
    logic [ARG_W-1:0] args;
    logic             take;
    logic [POS_W-1:0] pos;
    logic             ovf;

    ph            = phase;
    ins           = inside_token;
    beg           = token_begin;
    args          = args_found;
    emit_take     = 1'b0;
    emit_take_arg = 1'b0;
    take          = (byte_position < POS_W'(LINE_BYTES));
    ovf           = overflow_seen || !take;
    pos           = take ? POS_W'(byte_position + 1'b1) : byte_position;

    if (take) begin
      unique case (phase)
        PH_LEAD: begin
          if (!is_blank(c)) begin
            if (c == CH_LPAREN || is_sep(c)) begin
              ph = PH_NONAME;
            end else begin
              beg = byte_position;
              ins = 1'b1;
              ph  = PH_NAME;
            end
          end
        end
        PH_NAME: begin
          if (c == CH_LPAREN || is_blank(c) || is_sep(c)) begin
            emit_take = 1'b1;
            ins       = 1'b0;
            if (c == CH_LPAREN) ph = PH_BRACKET;
            else if (is_blank(c)) ph = PH_AFTER;
            else ph = PH_BLANKARGS;
          end
        end
        PH_AFTER: begin
          if (!is_blank(c)) begin
            if (c == CH_LPAREN) begin
              ph = PH_BRACKET;
            end else begin
              ph = PH_BLANKARGS;
              if (!is_sep(c)) begin
                if (c == CH_RPAREN || is_term(c)) begin
                  ph = PH_END;
                end else begin
                  beg = byte_position;
                  ins = 1'b1;
                end
              end
            end
          end
        end
        PH_BRACKET, PH_BLANKARGS: begin
          if (inside_token) begin
            if (is_sep(c) || is_blank(c) || c == CH_RPAREN) begin
              args          = ARG_W'(args_found + 1'b1);
              emit_take     = 1'b1;
              emit_take_arg = 1'b1;
              ins           = 1'b0;
              if (args >= ARG_W'(MAX_ARGS) || c == CH_RPAREN) ph = PH_END;
            end
          end else if (!is_blank(c) && !is_sep(c)) begin
            if (c == CH_RPAREN || is_term(c)) begin
              ph = PH_END;
            end else begin
              beg = byte_position;
              ins = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end

    take_total  = args;
    emit_close  = last && ins;
    close_arg   = (ph != PH_NAME);
    close_begin = beg;
    close_pos   = pos;
    if (emit_close && close_arg) args = ARG_W'(args + 1'b1);
    final_total = args;
    if (ovf) final_status = STATUS_TOO_LONG;
    else if (ph == PH_LEAD || ph == PH_NONAME) final_status = STATUS_NO_NAME;
    else final_status = STATUS_OK;

    if (last) begin
      // Close the line and start over
      phase_next         = PH_LEAD;
      byte_position_next = '0;
      token_begin_next   = '0;
      inside_token_next  = 1'b0;
      args_found_next    = '0;
      overflow_seen_next = 1'b0;
    end else begin
      phase_next         = ph;
      byte_position_next = pos;
      token_begin_next   = beg;
      inside_token_next  = ins;
      args_found_next    = args;
      overflow_seen_next = ovf;
    end
  end

  // Step record for the queue
  always_comb begin
    logic [POS_W-1:0] take_len;
    logic [POS_W-1:0] close_len;

    take_len       = POS_W'(byte_position - token_begin);
    close_len      = POS_W'(close_pos - close_begin);
    rec            = '0;
    rec.tok_valid  = emit_take || emit_close;
    if (emit_take) begin
      rec.tok_kind   = emit_take_arg ? KIND_ARG : KIND_NAME;
      rec.tok_offset = token_begin[7:0];
      rec.tok_length = take_len[8:0];
      rec.tok_total  = take_total[3:0];
    end else begin
      rec.tok_kind   = close_arg ? KIND_ARG : KIND_NAME;
      rec.tok_offset = close_begin[7:0];
      rec.tok_length = close_len[8:0];
      rec.tok_total  = final_total[3:0];
    end
    rec.sum_valid  = last;
    rec.sum_status = final_status;
    rec.sum_total  = final_total[3:0];
    push           = accept && (rec.tok_valid || rec.sum_valid);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_LEAD;
      byte_position <= '0;
      token_begin   <= '0;
      inside_token  <= 1'b0;
      args_found    <= '0;
      overflow_seen <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      byte_position <= byte_position_next;
      token_begin   <= token_begin_next;
      inside_token  <= inside_token_next;
      args_found    <= args_found_next;
      overflow_seen <= overflow_seen_next;
    end
  end

  `CAT_ASSERT_ALWAYS(a_args_bounded, args_found <= ARG_W'(MAX_ARGS))
  `CAT_ASSERT_ALWAYS(a_pos_bounded, byte_position <= POS_W'(LINE_BYTES))
  `CAT_ASSERT_SAME(a_no_token_after_end, phase == PH_END || phase == PH_NONAME,
                   !inside_token)
  `CAT_ASSERT_NEXT(a_line_restart, accept && last,
                   byte_position == '0 && phase == PH_LEAD && args_found == '0)

endmodule

>>> hw/rtl/cat_queue.sv
// Short queue of step records between scanner and result emitter.
// Depends on cat_pkg.
`timescale 1ns / 1ps

module cat_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  cat_pkg::step_rec_t push_rec,
  output logic               room,
  input  logic               pop,
  output logic               head_valid,
  output cat_pkg::step_rec_t head
);
  import cat_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  step_rec_t        slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign room       = (count != CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= PTR_W'(wr_ptr + 1'b1);
      if (pop) rd_ptr <= PTR_W'(rd_ptr + 1'b1);
      if (push && !pop) count <= CNT_W'(count + 1'b1);
      else if (pop && !push) count <= CNT_W'(count - 1'b1);
    end
  end

endmodule

>>> hw/rtl/cat_back.sv
// Back end: unpacks step records into result transactions through an
// output register. Depends on cat_pkg and cat_stream_if.
`timescale 1ns / 1ps
`include "command_argument_tokenizer_core_defines.svh"

module cat_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  cat_pkg::step_rec_t head,
  output logic               pop,
  cat_stream_if.source       token_out
);
  import cat_pkg::*;

  logic      out_valid;
  out_item_t out_data;
  logic      tok_done;
  logic      load;
  logic      sel_tok;
  out_item_t next_item;

  assign load    = head_valid && (!out_valid || token_out.ready);
  assign sel_tok = head.tok_valid && !tok_done;
  // Retire the entry once its last result is loaded
  assign pop     = load && !(sel_tok && head.sum_valid);

  always_comb begin
    if (sel_tok) begin
      next_item.token_kind   = head.tok_kind;
      next_item.token_offset = head.tok_offset;
      next_item.token_size   = head.tok_length;
      next_item.arg_total    = head.tok_total;
      next_item.parse_status = STATUS_OK;
      next_item.end_of_run   = 1'b0;
    end else begin
      next_item.token_kind   = KIND_SUMMARY;
      next_item.token_offset = '0;
      next_item.token_size   = '0;
      next_item.arg_total    = head.sum_total;
      next_item.parse_status = head.sum_status;
      next_item.end_of_run   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      tok_done  <= 1'b0;
    end else begin
      if (load) out_valid <= 1'b1;
      else if (token_out.ready) out_valid <= 1'b0;
      if (load) tok_done <= !pop;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_data <= next_item;
  end

  assign token_out.valid = out_valid;
  assign token_out.data  = out_data;

  `CAT_ASSERT_SAME(a_split_entry, tok_done,
                   head_valid && head.tok_valid && head.sum_valid)
  `CAT_ASSERT_SAME(a_entry_not_empty, head_valid, head.tok_valid || head.sum_valid)

endmodule

>>> hw/rtl/command_argument_tokenizer_core.sv
// Top level of the command argument tokenizer: scanner, queue, emitter.
// Depends on cat_pkg, cat_stream_if, cat_front, cat_queue and cat_back.
//
//   channel    dir  payload                                   role
//   byte_in    in   byte_value, last_byte                     one line byte
//   token_out  out  token_kind, token_offset, token_size,     name, argument
//                   arg_total, parse_status, end_of_run       or line summary
//
// The scanner takes one byte per cycle while the queue has room; a byte's
// results pass through the step queue and then the output register.
// The emitter sends one result per cycle while token_out is ready; a last
// line byte that closes a token yields two results, token then summary.
// The four-entry step queue absorbs that burst; byte_in stalls only while it
// is full, and token_out stalls back into the queue without losing data.
// Reset (rst, synchronous) returns the scanner to leading-blank skip and
// empties queue and output register.
`timescale 1ns / 1ps

module command_argument_tokenizer_core #(
  parameter int LINE_BYTES = cat_pkg::LINE_BYTES_DEFAULT,
  parameter int MAX_ARGS   = cat_pkg::MAX_ARGS_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  cat_stream_if.sink   byte_in,
  cat_stream_if.source token_out
);
  import cat_pkg::*;

  // Front to queue
  logic      push;
  step_rec_t push_rec;
  logic      room;
  // Queue to back
  logic      pop;
  logic      head_valid;
  step_rec_t head;

  // Scanner: classify each byte and track the line phase
  cat_front #(
    .LINE_BYTES (LINE_BYTES),
    .MAX_ARGS   (MAX_ARGS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .byte_in (byte_in),
    .room    (room),
    .push    (push),
    .rec     (push_rec)
  );

  // Hold step records so both sides stall on their own
  cat_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_rec   (push_rec),
    .room       (room),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Emitter: token first, then summary, one transaction per cycle while token_out is ready
  cat_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .token_out  (token_out)
  );

endmodule

>>> bench/command_argument_tokenizer_core_tb.sv
// Self-checking bench for command_argument_tokenizer_core: drives command lines byte by
// byte and checks every name, argument and line summary against a built-in line scanner.
// Depends on cat_pkg, cat_stream_if and the tokenizer RTL.
`timescale 1ns / 1ps

module command_argument_tokenizer_core_tb;
  import cat_pkg::*;

  typedef logic [7:0] char_t;

  localparam int LINE_BYTES = LINE_BYTES_DEFAULT;
  localparam int MAX_ARGS = MAX_ARGS_DEFAULT;
  localparam int RANDOM_ITEMS = 300;
  // Longest legal quiet stretch is the receiver hold-off (HOLD_CYCLES) plus a
  // sender gap; allow many times that before calling the run hung.
  localparam int IDLE_CYCLE_LIMIT = 1000;
  localparam int HOLD_CYCLES = 120;
  localparam int SETTLE_CYCLES = 16;
  localparam int REPORT_LIMIT = 10;

  // Receiver stall patterns
  typedef enum int {
    RX_ALWAYS,
    RX_COIN,
    RX_MOSTLY,
    RX_PERIODIC
  } rx_mode_t;

  logic clk = 1'b0;
  logic rst;

  cat_stream_if #(.payload_t(in_item_t)) byte_in_if ();
  cat_stream_if #(.payload_t(out_item_t)) token_out_if ();

  command_argument_tokenizer_core #(
    .LINE_BYTES(LINE_BYTES),
    .MAX_ARGS(MAX_ARGS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .byte_in(byte_in_if),
    .token_out(token_out_if)
  );

  always #5 clk = ~clk;

  // Line scanner state, mirrored from the block's behavior
  phase_t scan_phase;
  int line_pos;
  int tok_start;
  bit in_token;
  int arg_count;
  bit line_overflow;

  out_item_t expected_tokens[$];
  char_t line_buf[$];

  int mismatch_count = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  bit steady_send = 0;
  bit hold_request = 0;

  // ---------------------------------------------------------------------------
  // Character classes
  // ---------------------------------------------------------------------------
  function automatic bit blank_ch(char_t c);
    return c == CH_SPACE || c == CH_TAB || c == CH_CR;
  endfunction

  function automatic bit sep_ch(char_t c);
    return c == CH_COMMA || c == CH_SEMI;
  endfunction

  function automatic bit end_ch(char_t c);
    return c == CH_LF || c == CH_NUL;
  endfunction

  // ---------------------------------------------------------------------------
  // Line scanner: works out the results each accepted byte causes
  // ---------------------------------------------------------------------------
  function automatic void clear_line_state();
    scan_phase = PH_LEAD;
    line_pos = 0;
    tok_start = 0;
    in_token = 0;
    arg_count = 0;
    line_overflow = 0;
  endfunction

  // Queue one expected result; the running argument count rides along.
  function automatic void push_token(logic [1:0] kind, int offset, int length,
                                     logic [1:0] status, logic fin);
    out_item_t r;
    r.token_kind = kind;
    r.token_offset = 8'(offset);
    r.token_size = 9'(length);
    r.arg_total = 4'(arg_count);
    r.parse_status = status;
    r.end_of_run = fin;
    expected_tokens.push_back(r);
  endfunction

  // Look at a possible argument start: skip delimiters, stop on ')' or a
  // line end, otherwise open a token here.
  function automatic void open_argument(char_t c, int idx);
    if (blank_ch(c) || sep_ch(c)) return;
    if (c == CH_RPAREN || end_ch(c)) begin
      scan_phase = PH_END;
      return;
    end
    tok_start = idx;
    in_token = 1;
  endfunction

  function automatic void scan_char(char_t c, int idx);
    case (scan_phase)
      PH_LEAD: begin
        if (!blank_ch(c)) begin
          if (c == CH_LPAREN || sep_ch(c)) begin
            scan_phase = PH_NONAME;
          end else begin
            tok_start = idx;
            in_token = 1;
            scan_phase = PH_NAME;
          end
        end
      end
      PH_NAME: begin
        if (c == CH_LPAREN || blank_ch(c) || sep_ch(c)) begin
          push_token(KIND_NAME, tok_start, idx - tok_start, STATUS_OK, 1'b0);
          in_token = 0;
          if (c == CH_LPAREN) scan_phase = PH_BRACKET;
          else if (blank_ch(c)) scan_phase = PH_AFTER;
          else scan_phase = PH_BLANKARGS;
        end
      end
      PH_AFTER: begin
        if (!blank_ch(c)) begin
          if (c == CH_LPAREN) begin
            scan_phase = PH_BRACKET;
          end else begin
            scan_phase = PH_BLANKARGS;
            open_argument(c, idx);
          end
        end
      end
      PH_BRACKET, PH_BLANKARGS: begin
        if (in_token) begin
          if (sep_ch(c) || blank_ch(c) || c == CH_RPAREN) begin
            arg_count++;
            push_token(KIND_ARG, tok_start, idx - tok_start, STATUS_OK, 1'b0);
            in_token = 0;
            if (arg_count >= MAX_ARGS) scan_phase = PH_END;
            else open_argument(c, idx);
          end
        end else begin
          open_argument(c, idx);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void predict_byte(char_t c, logic last);
    logic [1:0] status;
    // Bytes past the line limit only mark the overflow.
    if (line_pos >= LINE_BYTES) begin
      line_overflow = 1;
    end else begin
      scan_char(c, line_pos);
      line_pos++;
    end
    if (last) begin
      // Close a token still open, then summarize the line.
      if (in_token) begin
        if (scan_phase == PH_NAME) begin
          push_token(KIND_NAME, tok_start, line_pos - tok_start, STATUS_OK, 1'b0);
        end else begin
          arg_count++;
          push_token(KIND_ARG, tok_start, line_pos - tok_start, STATUS_OK, 1'b0);
        end
        in_token = 0;
      end
      if (line_overflow) status = STATUS_TOO_LONG;
      else if (scan_phase == PH_LEAD || scan_phase == PH_NONAME) status = STATUS_NO_NAME;
      else status = STATUS_OK;
      push_token(KIND_SUMMARY, 0, 0, status, 1'b1);
      clear_line_state();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Line content generation
  // ---------------------------------------------------------------------------
  function automatic char_t blank_pick();
    case ($urandom_range(0, 2))
      0: return CH_SPACE;
      1: return CH_TAB;
      default: return CH_CR;
    endcase
  endfunction

  // Any delimiter between tokens: a blank or a separator.
  function automatic char_t gap_pick();
    case ($urandom_range(0, 3))
      0: return CH_COMMA;
      1: return CH_SEMI;
      default: return blank_pick();
    endcase
  endfunction

  // A character with no meaning to the scanner.
  function automatic char_t plain_pick();
    char_t c;
    do begin
      c = char_t'($urandom_range(0, 255));
    end while (blank_ch(c) || sep_ch(c) || end_ch(c) || c == CH_LPAREN ||
               c == CH_RPAREN);
    return c;
  endfunction

  // Noise: half full-range bytes, half characters the scanner reacts to.
  function automatic char_t any_pick();
    if ($urandom_range(0, 1)) return char_t'($urandom_range(0, 255));
    case ($urandom_range(0, 8))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_CR;
      3: return CH_LF;
      4: return CH_NUL;
      5: return CH_LPAREN;
      6: return CH_RPAREN;
      7: return CH_COMMA;
      default: return CH_SEMI;
    endcase
  endfunction

  // A name or argument body; a line end inside a token is an ordinary byte.
  function automatic void append_word(int len);
    for (int i = 0; i < len; i++) begin
      if (i > 0 && $urandom_range(0, 15) == 0)
        line_buf.push_back($urandom_range(0, 1) ? CH_LF : CH_NUL);
      else
        line_buf.push_back(plain_pick());
    end
  endfunction

  function automatic void append_text(string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  // Well-formed command line with random content and random ending.
  function automatic void build_command_line(int arg_req);
    line_buf.delete();
    repeat ($urandom_range(0, 2)) line_buf.push_back(blank_pick());
    append_word($urandom_range(1, 6));
    if ($urandom_range(0, 1)) begin
      repeat ($urandom_range(0, 1)) line_buf.push_back(blank_pick());
      line_buf.push_back(CH_LPAREN);
    end else begin
      line_buf.push_back(gap_pick());
    end
    for (int i = 0; i < arg_req; i++) begin
      append_word($urandom_range(1, 5));
      // Leave the final argument open now and then so the last byte closes it.
      if (i + 1 < arg_req || $urandom_range(0, 3) != 0)
        repeat ($urandom_range(1, 2)) line_buf.push_back(gap_pick());
    end
    case ($urandom_range(0, 3))
      0: ;
      1: line_buf.push_back(CH_RPAREN);
      2: begin
        line_buf.push_back(CH_LF);
        repeat ($urandom_range(0, 3)) line_buf.push_back(any_pick());
      end
      default: repeat ($urandom_range(1, 3)) line_buf.push_back(any_pick());
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  // Offer one byte and hold it until the block takes it. Gaps open only at
  // burst boundaries, and never while a steady stream is asked for.
  task automatic send_byte(char_t c, logic last);
    in_item_t item;
    int gap_cycles;
    gap_cycles = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!steady_send && $urandom_range(0, 3) != 0) gap_cycles = $urandom_range(1, 8);
    end
    burst_left--;
    if (gap_cycles > 0) begin
      @(negedge clk);
      byte_in_if.valid <= 1'b0;
      repeat (gap_cycles - 1) @(negedge clk);
    end
    item.byte_value = c;
    item.last_byte = last;
    @(negedge clk);
    byte_in_if.valid <= 1'b1;
    byte_in_if.data <= item;
    do @(posedge clk); while (!byte_in_if.ready);
    predict_byte(c, last);
  endtask

  // Send line_buf[from..upto-1]; the line's final byte carries the last mark.
  task automatic send_line_span(int from, int upto);
    for (int i = from; i < upto; i++) send_byte(line_buf[i], i == line_buf.size() - 1);
  endtask

  // Drop valid and wait until every expected result has come out.
  task automatic wait_for_results();
    @(negedge clk);
    byte_in_if.valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Short lines for field extremes and each special case of the scanner.
  task automatic test_directed_lines();
    // Single byte line, name of value 0xFF closed by the last mark
    line_buf.delete();
    line_buf.push_back(8'hFF);
    send_line_span(0, line_buf.size());
    // All blanks: no name
    line_buf.delete();
    append_text(" \t\r");
    send_line_span(0, line_buf.size());
    // First non-blank is a bracket or separator: no name
    line_buf.delete();
    append_text("(");
    send_line_span(0, line_buf.size());
    line_buf.delete();
    append_text(";x");
    send_line_span(0, line_buf.size());
    line_buf.delete();
    append_text(",");
    send_line_span(0, line_buf.size());
    // Bracket form: NUL inside an argument, ')' at a token start ends parsing
    line_buf.delete();
    append_text("x(a");
    line_buf.push_back(CH_NUL);
    append_text(",)q");
    send_line_span(0, line_buf.size());
    // Newline inside the name is ordinary; at a token start it ends parsing
    line_buf.delete();
    append_text("y\n a \nb");
    send_line_span(0, line_buf.size());
    // Blank form: ')' at a token start ends parsing
    line_buf.delete();
    append_text("z )w");
    send_line_span(0, line_buf.size());
  endtask

  // Reach the argument limit: beyond it, with it exactly, and the eighth
  // argument left open until the last byte.
  task automatic test_argument_limit();
    build_command_line(12);
    send_line_span(0, line_buf.size());
    build_command_line(MAX_ARGS);
    send_line_span(0, line_buf.size());
    line_buf.delete();
    append_text("g ");
    for (int i = 0; i < MAX_ARGS; i++) begin
      append_word(2);
      if (i < MAX_ARGS - 1) line_buf.push_back(CH_COMMA);
    end
    send_line_span(0, line_buf.size());
  endtask

  // Lines at and past the line limit.
  task automatic test_line_overflow();
    // Exactly the limit: a name of full length, no overflow
    line_buf.delete();
    repeat (LINE_BYTES) line_buf.push_back(plain_pick());
    send_line_span(0, line_buf.size());
    // One byte over with an open argument: it is closed at the limit
    line_buf.delete();
    append_text("f(");
    repeat (LINE_BYTES - 1) line_buf.push_back(plain_pick());
    send_line_span(0, line_buf.size());
    // Too long outranks no name
    line_buf.delete();
    repeat (LINE_BYTES + 1) line_buf.push_back(blank_pick());
    send_line_span(0, line_buf.size());
  endtask

  // Fill the block while the receiver holds off, then pause mid-line until
  // everything has drained.
  task automatic test_back_pressure();
    int half;
    steady_send = 1;
    hold_request = 1;
    repeat (2) begin
      build_command_line(7);
      send_line_span(0, line_buf.size());
    end
    steady_send = 0;
    build_command_line(6);
    half = line_buf.size() / 2;
    send_line_span(0, half);
    wait_for_results();
    send_line_span(half, line_buf.size());
  endtask

  // Mostly well-formed lines, some noise, a few past the line limit.
  task automatic test_random_lines();
    int sent;
    int pick;
    int pad_to;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        line_buf.delete();
        repeat ($urandom_range(1, 12)) line_buf.push_back(any_pick());
      end else begin
        build_command_line($urandom_range(0, 10));
        if (pick < 18) begin
          pad_to = $urandom_range(LINE_BYTES - 16, LINE_BYTES + 44);
          while (line_buf.size() < pad_to) line_buf.push_back(any_pick());
        end
      end
      sent += line_buf.size();
      send_line_span(0, line_buf.size());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stall patterns, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    rx_mode_t rx_mode;
    int mode_left;
    int hold_left;
    int rx_tick;
    rx_mode = RX_ALWAYS;
    mode_left = 0;
    hold_left = 0;
    rx_tick = 0;
    token_out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      rx_tick++;
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        token_out_if.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        case (rx_mode)
          RX_ALWAYS: token_out_if.ready <= 1'b1;
          RX_COIN: token_out_if.ready <= 1'($urandom_range(0, 1));
          RX_MOSTLY: token_out_if.ready <= ($urandom_range(0, 3) != 0);
          default: token_out_if.ready <= (rx_tick % 5 != 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result check: each accepted result against the oldest expectation
  // ---------------------------------------------------------------------------
  task automatic check_token(out_item_t got);
    out_item_t want;
    if (expected_tokens.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("%0t: unexpected result kind %0d offset %0d length %0d total %0d %s",
                 $realtime, got.token_kind, got.token_offset, got.token_size,
                 got.arg_total,
                 $sformatf("status %0d end %0b", got.parse_status, got.end_of_run));
      return;
    end
    want = expected_tokens.pop_front();
    if (got.token_kind !== want.token_kind || got.token_offset !== want.token_offset ||
        got.token_size !== want.token_size || got.arg_total !== want.arg_total ||
        got.parse_status !== want.parse_status || got.end_of_run !== want.end_of_run) begin
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
        $display("%0t: token mismatch", $realtime);
        $display("  expected kind %0d offset %0d length %0d total %0d status %0d end %0b",
                 want.token_kind, want.token_offset, want.token_size, want.arg_total,
                 want.parse_status, want.end_of_run);
        $display("  actual   kind %0d offset %0d length %0d total %0d status %0d end %0b",
                 got.token_kind, got.token_offset, got.token_size, got.arg_total,
                 got.parse_status, got.end_of_run);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && token_out_if.valid && token_out_if.ready) check_token(token_out_if.data);
  end

  // Watchdog: end the run if no transaction moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (byte_in_if.valid && byte_in_if.ready) ||
        (token_out_if.valid && token_out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    clear_line_state();
    rst = 1'b1;
    byte_in_if.valid = 1'b0;
    byte_in_if.data = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_lines();
    test_argument_limit();
    test_line_overflow();
    test_back_pressure();
    test_random_lines();

    // Drain, then give any stray result time to show up.
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> command_argument_tokenizer_core.f
+incdir+hw/rtl
hw/rtl/cat_pkg.sv
hw/rtl/cat_stream_if.sv
hw/rtl/cat_front.sv
hw/rtl/cat_queue.sv
hw/rtl/cat_back.sv
hw/rtl/command_argument_tokenizer_core.sv
bench/command_argument_tokenizer_core_tb.sv
